// File: rtl/slsu_pkg.sv
// ---------------------------------------------------------------------------
// slsu_pkg
// Shared types, constants and helpers for the stochastic LLG spin update.
// ---------------------------------------------------------------------------
package slsu_pkg;

  localparam int SitesDefault = 1024;
  localparam int FracDefault  = 24;

  localparam int CfgIdxW   = 4;
  localparam int InTdataW  = 304;
  localparam int OutTdataW = 96;

  // quotient bits per divider stage
  localparam int DivBits   = 2;
  localparam int DivQBits  = 32;
  localparam int DivStages = DivQBits / DivBits;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GYRO  = 4'd0,
    REG_DAMP  = 4'd1,
    REG_DT    = 4'd2,
    REG_NOISE = 4'd3
  } cfg_reg_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [30:0] GYRO_RESET  = 31'd16777216;
  localparam logic [30:0] DAMP_RESET  = 31'd9227469;
  localparam logic [30:0] DT_RESET    = 31'd8388608;
  localparam logic [30:0] NOISE_RESET = 31'd1677722;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [63:0] q64_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [63:0] r;
    logic [31:0] low;
    logic [31:0] q;
  } div_lane_t;

  function automatic q32_t sat32(q64_t v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic int nx1(int j);
    return (j == 2) ? 0 : j + 1;
  endfunction

  function automatic int nx2(int j);
    return (j == 0) ? 2 : j - 1;
  endfunction

  // one restoring division step
  function automatic div_lane_t div_step(div_lane_t x, logic [63:0] d);
    div_lane_t   y;
    logic [64:0] t;
    y = x;
    t = {x.r, x.low[31]};
    if (t >= {1'b0, d}) begin
      y.r = 64'(t - {1'b0, d});
      y.q = {x.q[30:0], 1'b1};
    end else begin
      y.r = t[63:0];
      y.q = {x.q[30:0], 1'b0};
    end
    y.low = {x.low[30:0], 1'b0};
    return y;
  endfunction

endpackage

// File: rtl/stochastic_llg_spin_update.sv
// ---------------------------------------------------------------------------
// stochastic_llg_spin_update
// Semi-implicit midpoint LLG spin integrator, one lattice site per transaction.
// ---------------------------------------------------------------------------
// The path from input transaction to result is 13 arithmetic stages, a divider
//   init stage, 16 divider stages of 2 quotient bits and an output register.
// Throughput: one transaction per cycle; a stalled output holds the whole pipe.
// Previous-value memory is read and written at input acceptance, so back to
//   back transactions on the same site need no forwarding.
// Reset clears config registers to defaults and all valid bits; memory is not
//   cleared. Load transactions produce no result.
module stochastic_llg_spin_update
  import slsu_pkg::*;
#(
  parameter int SITES     = SitesDefault,
  parameter int FRAC_BITS = FracDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // site, spin_x, spin_y, spin_z, field_x, field_y, field_z,
  // noise_x, noise_y, noise_z, zero pad
  input  logic [InTdataW-1:0]  s_tdata,
  // operation
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // new_spin_x, new_spin_y, new_spin_z
  output logic [OutTdataW-1:0] m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW = (SITES > 1) ? $clog2(SITES) : 1;
  localparam int NV = 14 + DivStages;
  localparam int DSH = 32 - FRAC_BITS;

  function automatic q64_t mulq(q32_t a, q32_t b);
    q64_t p;
    p = q64_t'(a) * q64_t'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [AW-1:0] site_index(logic [9:0] st);
    logic [31:0] r;
    r = {22'b0, st};
    for (int k = 9; k >= 0; k--) begin
      if (r >= (32'(SITES) << k)) r = r - (32'(SITES) << k);
    end
    return r[AW-1:0];
  endfunction

  // config
  logic [30:0] gyro, damp, dt, noise;
  q32_t        g_k, gd_k, nc_k;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro  <= GYRO_RESET;
      damp  <= DAMP_RESET;
      dt    <= DT_RESET;
      noise <= NOISE_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GYRO:  gyro  <= cfg_data[30:0];
        REG_DAMP:  damp  <= cfg_data[30:0];
        REG_DT:    dt    <= cfg_data[30:0];
        REG_NOISE: noise <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    g_k  <= sat32(mulq({1'b0, gyro}, {1'b0, dt}));
    gd_k <= sat32(mulq({1'b0, gyro}, {1'b0, damp}));
    nc_k <= sat32(mulq(gd_k, {1'b0, noise}));
  end

  // handshake
  logic adv, acc;
  logic [NV-1:0] vp;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign acc      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp       <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vp       <= {vp[NV-2:0], acc && (s_tuser == OP_STEP)};
      m_tvalid <= vp[NV-1];
    end
  end

  // previous-value memory
  logic [AW-1:0]  addr;
  logic [191:0]   mem [SITES];
  logic [191:0]   rd;

  assign addr = site_index(s_tdata[9:0]);

  always_ff @(posedge clk) begin
    if (acc) mem[addr] <= s_tdata[201:10];
    if (adv) rd <= mem[addr];
  end

  // arithmetic pipeline
  q32_t s1 [3], h1 [3], n1 [3];
  q64_t pc2 [3][2], pp2 [3][2];
  q32_t s2 [3], h2 [3], hp2 [3], n2 [3];
  q32_t cc3 [3], cp3 [3], s3 [3], h3 [3], hp3 [3], n3 [3];
  q64_t pdc4 [3], pdp4 [3];
  q32_t s4 [3], h4 [3], hp4 [3], n4 [3];
  q32_t e5 [3], s5 [3], n5 [3];
  q64_t mg6 [3], mn6 [3];
  q32_t s6 [3], hm7 [3], s7 [3];
  q64_t xs8 [3][2], sq8 [3];
  q32_t s8 [3], hm8 [3];
  q32_t b9 [3], q9 [3], hm9 [3];
  q64_t den9;
  q64_t pbh10 [3], pc10 [3][2], pbq10 [3];
  q32_t hm10 [3];
  q64_t den10;
  q32_t u11 [3], hm11 [3];
  q64_t part11 [3], den11;
  q64_t pu12 [3], part12 [3], den12;
  q64_t num13 [3], den13;

  q32_t hc5 [3], hq5 [3], c9 [3];
  q64_t one;

  assign one = q64_t'(1) <<< FRAC_BITS;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hc5[j] = sat32(q64_t'(h4[j]) + pdc4[j]);
      hq5[j] = sat32(q64_t'(hp4[j]) + pdp4[j]);
      c9[j]  = sat32(xs8[j][0] - xs8[j][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        s1[j] <= s_tdata[10 + 32*j +: 32];
        h1[j] <= s_tdata[106 + 32*j +: 32];
        n1[j] <= s_tdata[202 + 32*j +: 32];

        pc2[j][0] <= mulq(s1[nx1(j)], h1[nx2(j)]);
        pc2[j][1] <= mulq(s1[nx2(j)], h1[nx1(j)]);
        pp2[j][0] <= mulq(rd[32*nx1(j) +: 32], rd[96 + 32*nx2(j) +: 32]);
        pp2[j][1] <= mulq(rd[32*nx2(j) +: 32], rd[96 + 32*nx1(j) +: 32]);
        s2[j]  <= s1[j];
        h2[j]  <= h1[j];
        hp2[j] <= rd[96 + 32*j +: 32];
        n2[j]  <= n1[j];

        cc3[j] <= sat32(pc2[j][0] - pc2[j][1]);
        cp3[j] <= sat32(pp2[j][0] - pp2[j][1]);
        s3[j]  <= s2[j];
        h3[j]  <= h2[j];
        hp3[j] <= hp2[j];
        n3[j]  <= n2[j];

        pdc4[j] <= mulq({1'b0, damp}, cc3[j]);
        pdp4[j] <= mulq({1'b0, damp}, cp3[j]);
        s4[j]  <= s3[j];
        h4[j]  <= h3[j];
        hp4[j] <= hp3[j];
        n4[j]  <= n3[j];

        e5[j] <= sat32(((q64_t'(hc5[j]) <<< 1) + q64_t'(hc5[j]) - q64_t'(hq5[j])) >>> 1);
        s5[j] <= s4[j];
        n5[j] <= n4[j];

        mg6[j] <= mulq(g_k, e5[j]);
        mn6[j] <= mulq(nc_k, n5[j]);
        s6[j]  <= s5[j];

        hm7[j] <= sat32((mg6[j] + mn6[j]) >>> 1);
        s7[j]  <= s6[j];

        xs8[j][0] <= mulq(s7[nx1(j)], hm7[nx2(j)]);
        xs8[j][1] <= mulq(s7[nx2(j)], hm7[nx1(j)]);
        sq8[j]    <= mulq(hm7[j], hm7[j]);
        s8[j]     <= s7[j];
        hm8[j]    <= hm7[j];

        b9[j]  <= sat32(q64_t'(s8[j]) - q64_t'(c9[j]));
        q9[j]  <= sat32(one + sq8[j]);
        hm9[j] <= hm8[j];

        pbh10[j]   <= mulq(b9[j], hm9[j]);
        pc10[j][0] <= mulq(hm9[nx1(j)], b9[nx2(j)]);
        pc10[j][1] <= mulq(hm9[nx2(j)], b9[nx1(j)]);
        pbq10[j]   <= mulq(b9[j], q9[j]);
        hm10[j]    <= hm9[j];

        u11[j]    <= sat32(pbh10[nx1(j)] + pbh10[nx2(j)]);
        part11[j] <= pbq10[j] + pc10[j][0] - pc10[j][1];
        hm11[j]   <= hm10[j];

        pu12[j]   <= mulq(hm11[j], u11[j]);
        part12[j] <= part11[j];

        num13[j] <= part12[j] + pu12[j];
      end
      den9  <= one + sq8[0] + sq8[1] + sq8[2];
      den10 <= den9;
      den11 <= den10;
      den12 <= den11;
      den13 <= den12;
    end
  end

  // divider
  div_lane_t   dv   [DivStages+1][3];
  logic [63:0] dden [DivStages+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        logic [63:0] a;
        a = num13[j][63] ? 64'(-num13[j]) : 64'(num13[j]);
        dv[0][j].neg <= num13[j][63];
        dv[0][j].ovf <= {32'b0, a} >= ({32'b0, den13} << DSH);
        dv[0][j].r   <= a >> DSH;
        dv[0][j].low <= 32'(a << FRAC_BITS);
        dv[0][j].q   <= '0;
      end
      dden[0] <= den13;
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int j = 0; j < 3; j++) begin
          div_lane_t x;
          x = dv[k][j];
          for (int b = 0; b < DivBits; b++) begin
            x = div_step(x, dden[k]);
          end
          dv[k+1][j] <= x;
        end
        dden[k+1] <= dden[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        if (dv[DivStages][j].ovf || dv[DivStages][j].q[31]) begin
          m_tdata[32*j +: 32] <= dv[DivStages][j].neg ? 32'h80000000 : 32'h7fffffff;
        end else if (dv[DivStages][j].neg) begin
          m_tdata[32*j +: 32] <= 32'(-{1'b0, dv[DivStages][j].q[30:0]});
        end else begin
          m_tdata[32*j +: 32] <= {1'b0, dv[DivStages][j].q[30:0]};
        end
      end
    end
  end

endmodule

// File: rtl/slsu_checker.sv
// ---------------------------------------------------------------------------
// slsu_checker
// Port-level checks for the stochastic LLG spin update.
// ---------------------------------------------------------------------------
module slsu_checker
  import slsu_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OutTdataW-1:0] m_tdata,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result right after reset");

endmodule

bind stochastic_llg_spin_update slsu_checker u_slsu_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// File: tb/tb_stochastic_llg_spin_update.sv
// ---------------------------------------------------------------------------
// tb_stochastic_llg_spin_update
// Streams load and step transactions through the spin integrator and checks
// each new spin against a bit-exact fixed-point predictor. Coverage includes
// several register settings with their extremes and random idle on both sides.
// ---------------------------------------------------------------------------
module tb_stochastic_llg_spin_update;
  import slsu_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 4'hF;
  localparam int  Frac   = 24;
  localparam int  Drain  = 40;
  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  typedef q32_t site_in_t[9];
  typedef longint vec3_t[3];
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } spin_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata = '0;
  logic                 s_tuser = OP_LOAD;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = REG_GYRO;
  logic [31:0]          cfg_data = '0;

  stochastic_llg_spin_update i_dut (.*);

  longint gyro, damp, dt, noise_amp;
  q32_t   prev_spin[3][1024];
  q32_t   prev_field[3][1024];
  bit     site_loaded[1024];
  spin_t  spin_expect_q[$];
  int     mismatches = 0;
  bit     quiet = 1'b0;
  int     stall_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("tb_stochastic_llg_spin_update failed");
    $finish;
  end

  function automatic longint sat(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> Frac;
  endfunction

  function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t o);
    o[0] = sat(mulq(a[1], b[2]) - mulq(a[2], b[1]));
    o[1] = sat(mulq(a[2], b[0]) - mulq(a[0], b[2]));
    o[2] = sat(mulq(a[0], b[1]) - mulq(a[1], b[0]));
  endfunction

  function automatic void damp_field(input vec3_t s, input vec3_t h, output vec3_t o);
    vec3_t c;
    cross3(s, h, c);
    for (int j = 0; j < 3; j++) o[j] = sat(h[j] + mulq(damp, c[j]));
  endfunction

  function automatic longint div_q(longint n, longint d);
    bit        neg;
    bit [63:0] a, ud, qi, r, q;
    neg = n < 0;
    a   = neg ? -n : n;
    ud  = d;
    qi  = a / ud;
    r   = a % ud;
    if (qi > (64'd1 << (31 - Frac))) return neg ? QMin : QMax;
    q = qi << Frac;
    for (int i = Frac - 1; i >= 0; i--) begin
      r = r << 1;
      if (r >= ud) begin
        r = r - ud;
        q[i] = 1'b1;
      end
    end
    return sat(neg ? -longint'(q) : longint'(q));
  endfunction

  // expected new spin for a step transaction; every transaction updates the per-site history
  function automatic void llg_predict(logic op, logic [9:0] site, site_in_t v);
    vec3_t  s, h, n, sp, hp, h1, h2, hm, c, b, qf;
    longint g, nc, den, e, u, num;
    longint res[3];
    spin_t  r;
    for (int j = 0; j < 3; j++) begin
      s[j] = v[j];
      h[j] = v[3 + j];
      n[j] = v[6 + j];
      sp[j] = prev_spin[j][site];
      hp[j] = prev_field[j][site];
    end
    if (op == OP_STEP) begin
      damp_field(s, h, h1);
      damp_field(sp, hp, h2);
      g  = sat(mulq(gyro, dt));
      nc = sat(mulq(sat(mulq(gyro, damp)), noise_amp));
      for (int j = 0; j < 3; j++) begin
        e = sat((3 * h1[j] - h2[j]) >>> 1);
        hm[j] = sat((mulq(g, e) + mulq(nc, n[j])) >>> 1);
      end
      cross3(s, hm, c);
      for (int j = 0; j < 3; j++) b[j] = sat(s[j] - c[j]);
      den = (64'sd1 << Frac) + mulq(hm[0], hm[0]) + mulq(hm[1], hm[1])
            + mulq(hm[2], hm[2]);
      for (int j = 0; j < 3; j++) qf[j] = sat((64'sd1 << Frac) + mulq(hm[j], hm[j]));
      for (int j = 0; j < 3; j++) begin
        u = sat(mulq(b[nx1(j)], hm[nx1(j)]) + mulq(b[nx2(j)], hm[nx2(j)]));
        num = mulq(b[j], qf[j]) + mulq(hm[nx1(j)], b[nx2(j)])
              - mulq(hm[nx2(j)], b[nx1(j)]) + mulq(hm[j], u);
        res[j] = div_q(num, den);
      end
      r.x = res[0][31:0];
      r.y = res[1][31:0];
      r.z = res[2][31:0];
      spin_expect_q.push_back(r);
    end
    for (int j = 0; j < 3; j++) begin
      prev_spin[j][site]  = v[j];
      prev_field[j][site] = v[3 + j];
    end
    site_loaded[site] = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (quiet || rst) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    spin_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (spin_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = spin_expect_q.pop_front();
        if (m_tdata[31:0] !== want.x || m_tdata[63:32] !== want.y
            || m_tdata[95:64] !== want.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("spin mismatch: expected %h %h %h, got %h %h %h",
                     want.x, want.y, want.z,
                     m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]);
        end
      end
    end
  end

  task automatic send_site(logic op, logic [9:0] site, site_in_t v);
    logic [InTdataW-1:0] d;
    d = '0;
    d[9:0] = site;
    for (int k = 0; k < 9; k++) d[10 + 32 * k +: 32] = v[k];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    llg_predict(op, site, v);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (spin_expect_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GYRO:  gyro      = longint'(val[30:0]);
      REG_DAMP:  damp      = longint'(val[30:0]);
      REG_DT:    dt        = longint'(val[30:0]);
      REG_NOISE: noise_amp = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] g, logic [31:0] a, logic [31:0] t, logic [31:0] n);
    wait_idle();
    write_reg(REG_GYRO, g);
    write_reg(REG_DAMP, a);
    write_reg(REG_DT, t);
    write_reg(REG_NOISE, n);
  endtask

  function automatic q32_t rand_word();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4:  return $urandom;
      5:              return 32'sh7fffffff;
      6:              return 32'sh80000000;
      7:              return 32'sh01000000;
      default:        return $signed($urandom_range(0, 32'h04000000)) - 32'sh02000000;
    endcase
  endfunction

  function automatic site_in_t fill(q32_t s, q32_t h, q32_t n);
    site_in_t v;
    for (int k = 0; k < 3; k++) begin
      v[k] = s;
      v[3 + k] = h;
      v[6 + k] = n;
    end
    return v;
  endfunction

  task automatic test_directed_extremes();
    site_in_t v;
    send_site(OP_LOAD, 10'd0, fill(32'sh01000000, 32'sh00800000, 0));
    send_site(OP_LOAD, 10'd1023, fill(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    send_site(OP_STEP, 10'd0, fill(32'sh01000000, 32'sh00800000, 32'sh01000000));
    send_site(OP_STEP, 10'd1023, fill(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    send_site(OP_STEP, 10'd1023, fill(32'sh80000000, 32'sh80000000, 32'sh7fffffff));
    send_site(OP_STEP, 10'd0, fill(0, 0, 0));
    send_site(OP_STEP, 10'd0, fill(-1, 32'sh7fffffff, -1));
    v = fill(32'sh00b504f3, 32'sh00400000, 32'shff000000);
    v[2] = 0;
    v[5] = 32'sh03000000;
    send_site(OP_STEP, 10'd0, v);
    send_site(OP_LOAD, 10'd512, fill(32'sh80000000, 32'sh7fffffff, 0));
    send_site(OP_STEP, 10'd512, fill(32'sh00100000, 32'sh10000000, 32'sh80000000));
    send_site(OP_STEP, 10'd0, fill(32'sh01000000, 32'sh00800000, 0));
    send_site(OP_STEP, 10'd0, fill(32'sh01000000, 32'sh00800000, 0));
  endtask

  task automatic test_random(int count);
    site_in_t   v;
    logic [9:0] site;
    logic       op;
    for (int i = 0; i < count; i++) begin
      site = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
      op = (site_loaded[site] && $urandom_range(0, 4) != 0) ? OP_STEP : OP_LOAD;
      for (int k = 0; k < 9; k++) v[k] = rand_word();
      send_site(op, site, v);
    end
  endtask

  initial begin
    gyro = longint'(GYRO_RESET);
    damp = longint'(DAMP_RESET);
    dt = longint'(DT_RESET);
    noise_amp = longint'(NOISE_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_random(350);
    set_regs(32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    write_reg(REG_UNUSED, 32'h12345678);
    test_directed_extremes();
    test_random(250);
    set_regs(0, 0, 0, 0);
    test_random(200);
    set_regs($urandom_range(0, 32'h04000000), $urandom_range(0, 32'h02000000),
             $urandom_range(0, 32'h02000000), $urandom_range(0, 32'h01000000));
    test_random(350);
    set_regs({1'b1, 31'(GYRO_RESET)}, 32'(DAMP_RESET), 32'(DT_RESET), 32'(NOISE_RESET));
    test_random(250);
    quiet = 1'b1;
    test_random(200);
    wait_idle();
    if (mismatches == 0 && spin_expect_q.size() == 0) begin
      $display("tb_stochastic_llg_spin_update passed");
    end else begin
      $display("tb_stochastic_llg_spin_update failed");
    end
    $finish;
  end

endmodule
